// ===== hdl/md5dc_pkg.sv =====
// ----------------------------------------------------------------------------
// md5dc_pkg
// Shared types, constants and round functions of the MD5 digest checker.
// ----------------------------------------------------------------------------
package md5dc_pkg;

  // one queued input word, valid byte count already saturated to four
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nvalid;
    logic        last;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_ADD,
    ST_DONE
  } core_state_t;

  // what follows the running compression
  typedef enum logic [1:0] {
    AF_NONE,
    AF_PADBLK,
    AF_LENBLK,
    AF_FIN
  } after_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [31:0] PAD_WORD = 32'h00000080;

  localparam logic [31:0] K_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'd0:  s = 5'd7;
      4'd1:  s = 5'd12;
      4'd2:  s = 5'd17;
      4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;
      4'd5:  s = 5'd9;
      4'd6:  s = 5'd14;
      4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;
      4'd9:  s = 5'd11;
      4'd10: s = 5'd16;
      4'd11: s = 5'd23;
      4'd12: s = 5'd6;
      4'd13: s = 5'd10;
      4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] i4;
    logic [3:0] g;
    i4 = rnd[3:0];
    case (rnd[5:4])
      2'd0:    g = i4;
      2'd1:    g = 4'(i4 * 4'd5 + 4'd1);
      2'd2:    g = 4'(i4 * 4'd3 + 4'd5);
      default: g = 4'(i4 * 4'd7);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (r)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (d & b) | (~d & c);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

// ===== hdl/md5dc_front.sv =====
// ----------------------------------------------------------------------------
// md5dc_front
// Input intake: takes message words, clamps the byte count, queues two deep.
// ----------------------------------------------------------------------------
module md5dc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_message_word,
  input  logic [2:0]          in_valid_bytes,
  input  logic                in_last_word,
  output logic                q_valid,
  output md5dc_pkg::entry_t   q_entry,
  input  logic                q_pop
);

  md5dc_pkg::entry_t q_mem [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;
  logic              push;
  md5dc_pkg::entry_t new_entry;

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_entry  = q_mem[rd_ptr_r];

  always_comb begin
    new_entry.word   = in_message_word;
    new_entry.nvalid = (in_valid_bytes > 3'd4) ? 3'd4 : in_valid_bytes;
    new_entry.last   = in_last_word;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = 2'(count_r + {1'b0, push} - {1'b0, q_pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= new_entry;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n) count_r <= 2'd2)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> count_r != 2'd0)
    else $error("pop from empty queue");

endmodule

// ===== hdl/md5dc_core.sv =====
// ----------------------------------------------------------------------------
// md5dc_core
// Block buffer, padding control and a single MD5 round unit, one round a cycle.
// ----------------------------------------------------------------------------
module md5dc_core #(
  parameter int LENGTH_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  md5dc_pkg::entry_t q_entry,
  output logic              q_pop,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [63:0]       res_high,
  output logic [63:0]       res_low
);

  localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LENGTH_BITS);

  md5dc_pkg::core_state_t state_r, state_nxt;
  md5dc_pkg::after_t      after_r;

  logic [31:0] buf_r [16];
  logic [31:0] chain_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [5:0]  rnd_r;
  logic [4:0]  lim_r;
  logic        len_r;
  logic [3:0]  fill_r;
  logic [31:0] bytes_r;

  logic [63:0] len_bits;
  logic [3:0]  g;
  logic [31:0] m_word;
  logic [31:0] sum;
  logic [31:0] nb;
  logic [31:0] sum_ab [4];

  // intake classification of the popped word
  logic [31:0] byte_mask;
  logic [31:0] last_word;
  logic [6:0]  pos;
  logic [4:0]  pad_idx;
  logic        spill;

  assign q_pop     = (state_r == md5dc_pkg::ST_IDLE) && q_valid;
  assign res_valid = (state_r == md5dc_pkg::ST_DONE);
  assign res_high  = {md5dc_pkg::swap32(chain_r[0]), md5dc_pkg::swap32(chain_r[1])};
  assign res_low   = {md5dc_pkg::swap32(chain_r[2]), md5dc_pkg::swap32(chain_r[3])};

  assign len_bits = {29'd0, bytes_r, 3'd0} & LEN_MASK;

  always_comb begin
    g = md5dc_pkg::msg_index(rnd_r);
    if ({1'b0, g} < lim_r) begin
      m_word = buf_r[g];
    end else if (len_r && g == 4'd14) begin
      m_word = len_bits[31:0];
    end else if (len_r && g == 4'd15) begin
      m_word = len_bits[63:32];
    end else begin
      m_word = '0;
    end
    sum = a_r + md5dc_pkg::round_f(rnd_r[5:4], b_r, c_r, d_r) + md5dc_pkg::K_TAB[rnd_r]
          + m_word;
    nb  = b_r + md5dc_pkg::rotl(sum, md5dc_pkg::rot_amt(rnd_r));
    sum_ab[0] = chain_r[0] + a_r;
    sum_ab[1] = chain_r[1] + b_r;
    sum_ab[2] = chain_r[2] + c_r;
    sum_ab[3] = chain_r[3] + d_r;
  end

  always_comb begin
    case (q_entry.nvalid)
      3'd0:    byte_mask = 32'h00000000;
      3'd1:    byte_mask = 32'h000000ff;
      3'd2:    byte_mask = 32'h0000ffff;
      3'd3:    byte_mask = 32'h00ffffff;
      default: byte_mask = 32'hffffffff;
    endcase
    last_word = q_entry.word & byte_mask;
    if (q_entry.nvalid != 3'd4) begin
      last_word = last_word | (md5dc_pkg::PAD_WORD << {q_entry.nvalid[1:0], 3'd0});
    end
    pos     = {1'b0, fill_r, 2'd0} + {4'd0, q_entry.nvalid};
    pad_idx = pos[6:2];
    spill   = (pos == 7'd64);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      md5dc_pkg::ST_IDLE: begin
        if (q_valid && (q_entry.last || fill_r == 4'd15)) begin
          state_nxt = md5dc_pkg::ST_RUN;
        end
      end
      md5dc_pkg::ST_RUN: begin
        if (rnd_r == 6'd63) begin
          state_nxt = md5dc_pkg::ST_ADD;
        end
      end
      md5dc_pkg::ST_ADD: begin
        case (after_r)
          md5dc_pkg::AF_NONE:   state_nxt = md5dc_pkg::ST_IDLE;
          md5dc_pkg::AF_FIN:    state_nxt = md5dc_pkg::ST_DONE;
          default:              state_nxt = md5dc_pkg::ST_RUN;
        endcase
      end
      md5dc_pkg::ST_DONE: begin
        if (res_ready) begin
          state_nxt = md5dc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = md5dc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= md5dc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r[0] <= md5dc_pkg::INIT_A;
      chain_r[1] <= md5dc_pkg::INIT_B;
      chain_r[2] <= md5dc_pkg::INIT_C;
      chain_r[3] <= md5dc_pkg::INIT_D;
      fill_r     <= 4'd0;
      bytes_r    <= 32'd0;
      rnd_r      <= 6'd0;
      lim_r      <= 5'd0;
      len_r      <= 1'b0;
      after_r    <= md5dc_pkg::AF_NONE;
    end else begin
      case (state_r)
        md5dc_pkg::ST_IDLE: begin
          a_r   <= chain_r[0];
          b_r   <= chain_r[1];
          c_r   <= chain_r[2];
          d_r   <= chain_r[3];
          rnd_r <= 6'd0;
          if (q_valid) begin
            if (!q_entry.last) begin
              bytes_r <= bytes_r + 32'd4;
              fill_r  <= fill_r + 4'd1;
              lim_r   <= 5'd16;
              len_r   <= 1'b0;
              after_r <= md5dc_pkg::AF_NONE;
            end else begin
              bytes_r <= bytes_r + {29'd0, q_entry.nvalid};
              if (spill) begin
                lim_r   <= 5'd16;
                len_r   <= 1'b0;
                after_r <= md5dc_pkg::AF_PADBLK;
              end else if (pos > 7'd55) begin
                lim_r   <= pad_idx + 5'd1;
                len_r   <= 1'b0;
                after_r <= md5dc_pkg::AF_LENBLK;
              end else begin
                lim_r   <= pad_idx + 5'd1;
                len_r   <= 1'b1;
                after_r <= md5dc_pkg::AF_FIN;
              end
            end
          end
        end
        md5dc_pkg::ST_RUN: begin
          a_r   <= d_r;
          d_r   <= c_r;
          c_r   <= b_r;
          b_r   <= nb;
          rnd_r <= 6'(rnd_r + 6'd1);
        end
        md5dc_pkg::ST_ADD: begin
          for (int i = 0; i < 4; i++) begin
            chain_r[i] <= sum_ab[i];
          end
          a_r   <= sum_ab[0];
          b_r   <= sum_ab[1];
          c_r   <= sum_ab[2];
          d_r   <= sum_ab[3];
          rnd_r <= 6'd0;
          case (after_r)
            md5dc_pkg::AF_NONE: fill_r <= 4'd0;
            md5dc_pkg::AF_PADBLK: begin
              lim_r   <= 5'd1;
              len_r   <= 1'b1;
              after_r <= md5dc_pkg::AF_FIN;
            end
            md5dc_pkg::AF_LENBLK: begin
              lim_r   <= 5'd0;
              len_r   <= 1'b1;
              after_r <= md5dc_pkg::AF_FIN;
            end
            default: ;
          endcase
        end
        md5dc_pkg::ST_DONE: begin
          if (res_ready) begin
            chain_r[0] <= md5dc_pkg::INIT_A;
            chain_r[1] <= md5dc_pkg::INIT_B;
            chain_r[2] <= md5dc_pkg::INIT_C;
            chain_r[3] <= md5dc_pkg::INIT_D;
            fill_r     <= 4'd0;
            bytes_r    <= 32'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // block buffer writes; a full last word puts the pad in the following word
  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      if (state_r == md5dc_pkg::ST_IDLE && q_valid) begin
        if (4'(i) == fill_r) begin
          buf_r[i] <= q_entry.last ? last_word : q_entry.word;
        end else if (q_entry.last && !spill && q_entry.nvalid == 3'd4 &&
                     4'(i) == 4'(fill_r + 4'd1)) begin
          buf_r[i] <= md5dc_pkg::PAD_WORD;
        end
      end else if (state_r == md5dc_pkg::ST_ADD && after_r == md5dc_pkg::AF_PADBLK &&
                   i == 0) begin
        buf_r[i] <= md5dc_pkg::PAD_WORD;
      end
    end
  end

  a_rnd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (rnd_r != 6'd0) |-> (state_r == md5dc_pkg::ST_RUN || state_r == md5dc_pkg::ST_ADD))
    else $error("round counter active outside compression");
  a_lim_range: assert property (@(posedge clk) disable iff (!rst_n) lim_r <= 5'd16)
    else $error("buffer limit out of range");
  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == md5dc_pkg::ST_DONE && res_ready) |=>
      (state_r == md5dc_pkg::ST_IDLE && fill_r == 4'd0 && bytes_r == 32'd0))
    else $error("message state not cleared after result");

endmodule

// ===== hdl/md5_digest_checker_top.sv =====
// ----------------------------------------------------------------------------
// md5_digest_checker_top
// MD5 digest of a streamed message, compared with an expected digest.
// ----------------------------------------------------------------------------
// A word that does not finish a block is taken while the core idles; a block's 16th word
// starts a 64-round compression on the single round unit, followed by the chain add.
// The last word starts one or two compressions, and the digest then passes through
// the output register. A two-entry input queue accepts while the core works.
// Reset (synchronous, rst_n low) clears queue, chain value, counts, output valid and
// the expected digest; the block buffer and the output data are not cleared.
module md5_digest_checker_top #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_high,
  output logic [63:0] out_digest_low,
  output logic        out_digest_match,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam logic CFG_EXP_HIGH = 1'b0;
  localparam logic CFG_EXP_LOW  = 1'b1;

  logic              q_valid;
  logic              q_pop;
  md5dc_pkg::entry_t q_entry;
  logic              res_valid;
  logic              res_ready;
  logic [63:0]       res_high;
  logic [63:0]       res_low;

  logic [63:0] exp_high_r;
  logic [63:0] exp_low_r;
  logic        out_valid_r;
  logic [63:0] out_high_r;
  logic [63:0] out_low_r;
  logic        out_match_r;

  md5dc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_message_word (in_message_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_last_word    (in_last_word),
    .q_valid         (q_valid),
    .q_entry         (q_entry),
    .q_pop           (q_pop)
  );

  md5dc_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_high  (res_high),
    .res_low   (res_low)
  );

  assign res_ready        = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_digest_high  = out_high_r;
  assign out_digest_low   = out_low_r;
  assign out_digest_match = out_match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_high_r <= 64'd0;
      exp_low_r  <= 64'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXP_HIGH: exp_high_r <= cfg_wdata;
        CFG_EXP_LOW:  exp_low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_high_r  <= res_high;
      out_low_r   <= res_low;
      out_match_r <= (res_high == exp_high_r) && (res_low == exp_low_r);
    end
  end

endmodule

// ===== test/md5_digest_checker_scoreboard.sv =====
// ----------------------------------------------------------------------------
// md5_digest_checker_scoreboard
// Watches the word, digest and register ports of the MD5 digest checker. Keeps
// its own MD5 engine and expected-digest copy, predicts one digest per message
// and compares each digest transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module md5_digest_checker_scoreboard #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_digest_high,
  input  logic [63:0] out_digest_low,
  input  logic        out_digest_match,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CFG_DIGEST_HIGH = 1'b0;
  localparam logic CFG_DIGEST_LOW  = 1'b1;

  typedef struct {
    logic [63:0] high;
    logic [63:0] low;
    logic        match;
  } digest_t;

  localparam int SHIFT_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                    4, 11, 16, 23, 6, 10, 15, 21};

  digest_t     digest_q[$];
  logic [31:0] hash_state[4];
  logic [31:0] msg_block[16];
  logic [3:0]  word_count;
  logic [31:0] msg_bytes;
  logic [63:0] want_high, want_low;

  assign pending = digest_q.size();

  function automatic logic [31:0] rol(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic logic [31:0] bswap(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  task automatic md5_compress();
    logic [31:0] a, b, c, d, f, t;
    int g, r;
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    for (int i = 0; i < 64; i++) begin
      r = i / 16;
      case (r)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rol(a + f + md5dc_pkg::K_TAB[i] + msg_block[g], SHIFT_TAB[r * 4 + i % 4]);
      a = t;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
  endtask

  task automatic restart_message();
    hash_state = '{md5dc_pkg::INIT_A, md5dc_pkg::INIT_B, md5dc_pkg::INIT_C,
                   md5dc_pkg::INIT_D};
    word_count = '0;
    msg_bytes = '0;
  endtask

  task automatic clear_block();
    foreach (msg_block[i]) msg_block[i] = '0;
  endtask

  task automatic put_byte(input int pos, input logic [7:0] v);
    msg_block[pos / 4][(pos % 4) * 8 +: 8] = v;
  endtask

  task automatic predict_word(input logic [31:0] w, input logic [2:0] vb, input logic last);
    int nv, pos;
    logic [63:0] bit_len;
    digest_t e;
    if (!last) begin
      msg_block[word_count] = w;
      msg_bytes += 4;
      if (word_count == 4'd15) md5_compress();
      word_count++;
      return;
    end
    nv = (vb > 4) ? 4 : vb;
    msg_block[word_count] = (nv == 4) ? w : (w & ((32'd1 << (nv * 8)) - 1));
    msg_bytes += nv;
    pos = word_count * 4 + nv;
    if (pos >= 64) begin
      md5_compress();
      clear_block();
      pos = 0;
    end
    put_byte(pos, 8'h80);
    for (int k = pos + 1; k < 64; k++) put_byte(k, 8'h00);
    if (pos > 55) begin
      md5_compress();
      clear_block();
    end
    bit_len = {32'd0, msg_bytes} << 3;
    if (LENGTH_BITS < 64) bit_len &= (64'd1 << LENGTH_BITS) - 1;
    msg_block[14] = bit_len[31:0];
    msg_block[15] = bit_len[63:32];
    md5_compress();
    e.high = {bswap(hash_state[0]), bswap(hash_state[1])};
    e.low  = {bswap(hash_state[2]), bswap(hash_state[3])};
    e.match = (e.high == want_high) && (e.low == want_low);
    digest_q.push_back(e);
    restart_message();
  endtask

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] exp);
    $display("%0t: digest mismatch on %s: got %h, expected %h", $realtime, field, got, exp);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    want_high = '0;
    want_low = '0;
    clear_block();
    restart_message();
  end

  always @(posedge clk) begin
    digest_t e;
    if (!rst_n) begin
      want_high = '0;
      want_low = '0;
      restart_message();
      digest_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIGEST_HIGH: want_high = cfg_wdata;
          CFG_DIGEST_LOW:  want_low = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: digest transfer with no message finished", $realtime);
          fail_count++;
        end else begin
          e = digest_q.pop_front();
          if (out_digest_high !== e.high) report("digest_high", out_digest_high, e.high);
          if (out_digest_low !== e.low) report("digest_low", out_digest_low, e.low);
          if (out_digest_match !== e.match) report("digest_match", out_digest_match, e.match);
        end
      end
      if (in_valid && in_ready) predict_word(in_message_word, in_valid_bytes, in_last_word);
    end
  end

  final begin
    if (digest_q.size() != 0)
      $display("%0d digests never came out", digest_q.size());
  end

endmodule

// ===== test/md5_digest_checker_top_tb.sv =====
// ----------------------------------------------------------------------------
// md5_digest_checker_top_tb
// Streams messages into the MD5 digest checker with random gaps and stalls,
// rewrites the expected digest between phases and lets the scoreboard judge.
// ----------------------------------------------------------------------------
module md5_digest_checker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CFG_DIGEST_HIGH = 1'b0;
  localparam logic CFG_DIGEST_LOW  = 1'b1;
  localparam int   RANDOM_WORDS = 1250;
  localparam int   IDLE_LIMIT = 5000;
  localparam int   SETTLE_CYCLES = 150;
  localparam int   LONG_HOLD = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_message_word = '0;
  logic [2:0]  in_valid_bytes = '0;
  logic        in_last_word = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_digest_high, out_digest_low;
  logic        out_digest_match;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_DIGEST_HIGH;
  logic [63:0] cfg_wdata = '0;
  int          fail_count, pending;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int words_sent = 0;
  int msgs_sent = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  md5_digest_checker_top DUT (.*);

  md5_digest_checker_scoreboard scoreboard (.*);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("md5_digest_checker_top_tb NOT OK");
      $finish;
    end
  end

  // receiver: random stalls, one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ready = 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_ready = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_word(input logic [31:0] w, input logic [2:0] vb, input logic last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_message_word = w;
    in_valid_bytes = vb;
    in_last_word = last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
    if (last) msgs_sent++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_message(input int n);
    for (int i = 0; i < n; i++) send_word(rand_word(), 3'($urandom_range(0, 7)), 1'b0);
    send_word(rand_word(), 3'($urandom_range(0, 7)), 1'b1);
  endtask

  task automatic send_filled(input int n, input logic [2:0] last_vb);
    for (int i = 0; i < n; i++) send_word('1, 3'd4, 1'b0);
    send_word('1, last_vb, 1'b1);
  endtask

  // register writes only with the core quiet
  task automatic set_expected(input logic [63:0] hi, input logic [63:0] lo);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_DIGEST_HIGH;
    cfg_wdata = hi;
    @(negedge clk);
    cfg_index = CFG_DIGEST_LOW;
    cfg_wdata = lo;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_writes += 2;
  endtask

  task automatic random_messages(input int words);
    int target, r;
    target = words_sent + words;
    while (words_sent < target) begin
      r = $urandom_range(0, 19);
      send_message((r == 0) ? $urandom_range(30, 80) : $urandom_range(0, 18));
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // digest of the empty message
    set_expected(64'hd41d8cd98f00b204, 64'he9800998ecf8427e);
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'hffffffff, 3'd0, 1'b1);
    // single byte "a", then its digest as the expectation
    send_word(32'h00000061, 3'd1, 1'b1);
    set_expected(64'h0cc175b9c0f1b6a8, 64'h31c399e269772661);
    send_word(32'hffffff61, 3'd1, 1'b1);
    send_word(32'hffffffff, 3'd7, 1'b1);
    send_word(32'h12345678, 3'd5, 1'b0);
    send_word(32'habcdef01, 3'd3, 1'b1);
    // pad byte just fits, then spills into a second block, then fills one
    send_filled(13, 3'd3);
    send_filled(13, 3'd4);
    send_filled(15, 3'd4);

    set_expected('1, '1);
    random_messages(RANDOM_WORDS / 3);

    // long output stall while messages keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) send_message($urandom_range(0, 3));
    random_messages(RANDOM_WORDS / 6);

    set_expected('0, '0);
    random_messages(RANDOM_WORDS / 3);
    set_expected($urandom() << 32 | $urandom(), $urandom() << 32 | $urandom());
    calm = 1'b1;
    random_messages(RANDOM_WORDS / 6);

    in_valid = 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("%0d messages in %0d words hashed, %0d register writes",
             msgs_sent, words_sent, cfg_writes);
    $display("covered empty, one-byte, pad-boundary and long messages under stalls");
    if (fail_count == 0) $display("md5_digest_checker_top_tb OK");
    else $display("md5_digest_checker_top_tb NOT OK");
    $finish;
  end

endmodule
